/* design/m3kf_pkg.sv */
// Shared types and constants for the masked 3x3 kernel filter.
// Used by every module of the block; depends on nothing.
package m3kf_pkg;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_IGNORE = 3'd2;
  localparam logic [2:0] CFG_KTOP   = 3'd3;
  localparam logic [2:0] CFG_KMID   = 3'd4;
  localparam logic [2:0] CFG_KBOT   = 3'd5;

  localparam logic [7:0] ALPHA_BLANK = 8'hff;
  localparam int         ALPHA_LSB   = 24;

  // sum widths: 9 taps of 8-bit x signed 16-bit weights
  localparam int SUM_W  = 28;
  localparam int WSUM_W = 20;
  localparam int QW     = 27;
  localparam int DW     = 19;

  // emit bits: centre (filtered when filt is set), last column, last row
  typedef struct packed {
    logic [8:0][31:0] win;
    logic [9:0]       col;
    logic [15:0]      row;
    logic [2:0]       emit;
    logic             filt;
  } job_t;

  typedef enum logic {F_IDLE, F_LOAD} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_ACC, B_CHK, B_DIV, B_FIN, B_OUT} back_state_t;

endpackage

/* design/m3kf_if.sv */
// Stream interfaces for the pixel input and result output channels.
// Depends on nothing.
interface pix_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface pix_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic [9:0]  out_column;
  logic [15:0] out_row;
  logic        run_last;
  modport source (output valid, output pixel_out, output out_column, output out_row,
                  output run_last, input ready);
  modport sink   (input valid, input pixel_out, input out_column, input out_row,
                  input run_last, output ready);
endinterface

/* design/m3kf_front.sv */
// Front end: accepts pixels, keeps the line stores, window and position counters,
// and pushes one job per pixel that produces results. Uses m3kf_pkg, pix_in_if.
module m3kf_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  pix_in_if.sink            pix_in,
  input  logic [10:0]       image_width,
  input  logic [15:0]       image_height,
  input  logic              restart,
  input  logic              q_full,
  output m3kf_pkg::job_t    job,
  output logic              job_push
);
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;

  m3kf_pkg::front_state_t state, state_next;

  logic [31:0] upper_mem  [MAX_WIDTH];
  logic [31:0] middle_mem [MAX_WIDTH];
  logic [31:0] upper_rd, middle_rd, pix;
  logic [8:0][31:0] win, win_next;
  logic [CW-1:0] col_cnt;
  logic [15:0]   row_cnt;
  logic [WW-1:0] w_raw, eff_w;
  logic [15:0]   eff_h;
  logic          last_col, last_row, accept, load;

  always_comb begin
    w_raw = WW'(image_width);
    eff_w = w_raw;
    if (w_raw < WW'(3)) eff_w = WW'(3);
    if (w_raw > WW'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
    eff_h = (image_height < 16'd3) ? 16'd3 : image_height;
  end

  assign last_col = (WW'(col_cnt) == eff_w - WW'(1));
  assign last_row = (row_cnt == eff_h - 16'd1);

  always_comb begin
    state_next = state;
    case (state)
      m3kf_pkg::F_IDLE: if (accept) state_next = m3kf_pkg::F_LOAD;
      m3kf_pkg::F_LOAD: state_next = m3kf_pkg::F_IDLE;
      default:          state_next = m3kf_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    pix_in.ready = (state == m3kf_pkg::F_IDLE) && !q_full;
    load         = (state == m3kf_pkg::F_LOAD);
  end
  assign accept = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) state <= m3kf_pkg::F_IDLE;
    else     state <= state_next;
  end

  // line store read is registered; write back in the following cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      upper_rd  <= upper_mem[col_cnt];
      middle_rd <= middle_mem[col_cnt];
      pix       <= pix_in.pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      upper_mem[col_cnt]  <= middle_rd;
      middle_mem[col_cnt] <= pix;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i*3]   = win[i*3+1];
      win_next[i*3+1] = win[i*3+2];
    end
    win_next[2] = upper_rd;
    win_next[5] = middle_rd;
    win_next[8] = pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (load) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (load) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? 16'd0 : row_cnt + 16'd1;
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  always_comb begin
    job.win     = win_next;
    job.col     = 10'(col_cnt);
    job.row     = row_cnt;
    job.emit[0] = (row_cnt != 16'd0) && (col_cnt != '0);
    job.emit[1] = (row_cnt != 16'd0) && last_col;
    job.emit[2] = last_row;
    job.filt    = (row_cnt >= 16'd2) && (col_cnt >= CW'(2));
    job_push    = load && (job.emit != 3'b000);
  end

endmodule

/* design/m3kf_queue.sv */
// Two-entry job queue between front and back ends.
// Uses m3kf_pkg.
module m3kf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  m3kf_pkg::job_t push_job,
  input  logic           pop,
  output m3kf_pkg::job_t head,
  output logic           full,
  output logic           empty
);
  m3kf_pkg::job_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job popped from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("queue count lost a push");
endmodule

/* design/m3kf_back.sv */
// Back end: runs the weighted sums, a shared bit-serial divider and result
// sequencing into the output register. Uses m3kf_pkg, pix_out_if.
module m3kf_back (
  input  logic              clk,
  input  logic              rst,
  input  m3kf_pkg::job_t    head,
  input  logic              q_empty,
  output logic              pop,
  input  logic              ignore_blank,
  input  logic [2:0][47:0]  kernel,
  pix_out_if.source         pix_out
);
  localparam int SW = m3kf_pkg::SUM_W;
  localparam int WS = m3kf_pkg::WSUM_W;
  localparam int QW = m3kf_pkg::QW;
  localparam int DW = m3kf_pkg::DW;

  m3kf_pkg::back_state_t state, state_next;
  m3kf_pkg::job_t cur;
  logic [2:0]  mask, mask_next;
  logic [3:0]  k;
  logic [1:0]  ki, kj;
  logic signed [SW-1:0] sum_r, sum_a;
  logic signed [WS-1:0] wsum;
  logic [QW-1:0] dvd_r, dvd_a, q_r, q_a;
  logic [DW-1:0] rem_r, rem_a, dvs;
  logic [DW:0]   rs_r, rs_a;
  logic [4:0]    dcnt;
  logic          neg_r, neg_a;
  logic [31:0]   res0;
  logic [31:0]   tap;
  logic signed [15:0] wgt;
  logic          tap_used, blank_ctr, load;
  logic signed [24:0] prod_r, prod_a;
  logic [SW-1:0] mag_r, mag_a;
  logic [WS-1:0] mag_w;
  logic [7:0]    r8, a8;
  logic [31:0]   o_pix;
  logic [9:0]    o_col;
  logic [15:0]   o_row;

  assign blank_ctr = ignore_blank && (head.win[4][31:m3kf_pkg::ALPHA_LSB] == m3kf_pkg::ALPHA_BLANK);

  always_comb begin
    tap      = cur.win[k];
    wgt      = $signed(kernel[ki][kj*16 +: 16]);
    tap_used = !ignore_blank || (tap[31:m3kf_pkg::ALPHA_LSB] != m3kf_pkg::ALPHA_BLANK);
    prod_r   = $signed({1'b0, tap[7:0]}) * wgt;
    prod_a   = $signed({1'b0, tap[31:m3kf_pkg::ALPHA_LSB]}) * wgt;
    mag_r    = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
    mag_a    = sum_a[SW-1] ? SW'(-sum_a) : SW'(sum_a);
    mag_w    = wsum[WS-1] ? WS'(-wsum) : WS'(wsum);
    rs_r     = {rem_r, dvd_r[QW-1]};
    rs_a     = {rem_a, dvd_a[QW-1]};
  end

  // truncated quotient sign and clamp to a byte
  always_comb begin
    if (neg_r && q_r != '0)      r8 = 8'd0;
    else if (q_r > QW'(255))     r8 = 8'd255;
    else                         r8 = q_r[7:0];
    if (neg_a && q_a != '0)      a8 = 8'd0;
    else if (q_a > QW'(255))     a8 = 8'd255;
    else                         a8 = q_a[7:0];
  end

  // pick the lowest pending result
  always_comb begin
    if (mask[0]) begin
      o_pix = res0;    o_col = cur.col - 10'd1; o_row = cur.row - 16'd1;
      mask_next = mask & 3'b110;
    end else if (mask[1]) begin
      o_pix = cur.win[5]; o_col = cur.col; o_row = cur.row - 16'd1;
      mask_next = mask & 3'b100;
    end else begin
      o_pix = cur.win[8]; o_col = cur.col; o_row = cur.row;
      mask_next = 3'b000;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      m3kf_pkg::B_IDLE:
        if (!q_empty) begin
          state_next = (head.filt && !blank_ctr) ? m3kf_pkg::B_ACC : m3kf_pkg::B_OUT;
        end
      m3kf_pkg::B_ACC: if (k == 4'd8) state_next = m3kf_pkg::B_CHK;
      m3kf_pkg::B_CHK: state_next = (wsum == '0) ? m3kf_pkg::B_OUT : m3kf_pkg::B_DIV;
      m3kf_pkg::B_DIV: if (dcnt == 5'd0) state_next = m3kf_pkg::B_FIN;
      m3kf_pkg::B_FIN: state_next = m3kf_pkg::B_OUT;
      m3kf_pkg::B_OUT: if (load && mask_next == 3'b000) state_next = m3kf_pkg::B_IDLE;
      default:         state_next = m3kf_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == m3kf_pkg::B_IDLE) && !q_empty;
    load = (state == m3kf_pkg::B_OUT) && (!pix_out.valid || pix_out.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= m3kf_pkg::B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      m3kf_pkg::B_IDLE: begin
        cur   <= head;
        mask  <= head.emit;
        res0  <= head.win[4];
        k     <= 4'd0;
        ki    <= 2'd0;
        kj    <= 2'd0;
        sum_r <= '0;
        sum_a <= '0;
        wsum  <= '0;
      end
      m3kf_pkg::B_ACC: begin
        if (tap_used) begin
          sum_r <= sum_r + SW'(prod_r);
          sum_a <= sum_a + SW'(prod_a);
          wsum  <= wsum + WS'(wgt);
        end
        k <= k + 4'd1;
        if (kj == 2'd2) begin
          kj <= 2'd0;
          ki <= ki + 2'd1;
        end else begin
          kj <= kj + 2'd1;
        end
      end
      m3kf_pkg::B_CHK: begin
        dvd_r <= mag_r[QW-1:0];
        dvd_a <= mag_a[QW-1:0];
        dvs   <= mag_w[DW-1:0];
        neg_r <= sum_r[SW-1] ^ wsum[WS-1];
        neg_a <= sum_a[SW-1] ^ wsum[WS-1];
        rem_r <= '0;
        rem_a <= '0;
        dcnt  <= 5'(QW - 1);
      end
      m3kf_pkg::B_DIV: begin
        // one quotient bit per cycle for both sums
        dvd_r <= dvd_r << 1;
        dvd_a <= dvd_a << 1;
        if (rs_r >= {1'b0, dvs}) begin
          rem_r <= DW'(rs_r - {1'b0, dvs});
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= rs_r[DW-1:0];
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
        if (rs_a >= {1'b0, dvs}) begin
          rem_a <= DW'(rs_a - {1'b0, dvs});
          q_a   <= {q_a[QW-2:0], 1'b1};
        end else begin
          rem_a <= rs_a[DW-1:0];
          q_a   <= {q_a[QW-2:0], 1'b0};
        end
        dcnt <= dcnt - 5'd1;
      end
      m3kf_pkg::B_FIN: res0 <= {a8, r8, r8, r8};
      m3kf_pkg::B_OUT: if (load) mask <= mask_next;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (load) begin
      pix_out.valid <= 1'b1;
    end else if (pix_out.ready) begin
      pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_out.pixel_out  <= o_pix;
      pix_out.out_column <= o_col;
      pix_out.out_row    <= o_row;
      pix_out.run_last   <= (mask_next == 3'b000);
    end
  end

endmodule

/* design/masked_3x3_kernel_filter_core.sv */
// Top level of the masked 3x3 kernel filter: configuration registers, front
// end, job queue and back end. Uses m3kf_pkg, m3kf_if, m3kf_front/queue/back.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+------------------------------------------
//  pix_in    | in  | valid/ready      | pixel_in[31:0]
//  pix_out   | out | valid/ready      | pixel_out, out_column, out_row, run_last
//  cfg       | in  | cfg_we (no wait) | cfg_index[2:0], cfg_data[47:0]
//
// The front end takes a pixel while idle and the queue is not full, then reads the
// line stores and writes them back. The back end sends a job's results in turn; a
// filtered pixel first runs accumulate, check and, for a nonzero weight sum, divide
// and finish. Reset is synchronous; the line stores are not cleared. A stalled
// output holds the back end, the two-entry queue fills and stops the front end.
module masked_3x3_kernel_filter_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  pix_in_if.sink      pix_in,
  pix_out_if.source   pix_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  logic [10:0]      image_width;
  logic [15:0]      image_height;
  logic             ignore_blank;
  logic [2:0][47:0] kernel;
  logic             restart, job_push, q_full, q_empty, pop;
  m3kf_pkg::job_t   job, head;

  assign restart = cfg_we &&
    (cfg_index == m3kf_pkg::CFG_WIDTH || cfg_index == m3kf_pkg::CFG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd640;
      image_height <= 16'd480;
      ignore_blank <= 1'b1;
      kernel[0]    <= 48'h0;
      kernel[1]    <= 48'h0001_0001_0001;
      kernel[2]    <= 48'h0;
    end else if (cfg_we) begin
      case (cfg_index)
        m3kf_pkg::CFG_WIDTH:  image_width  <= cfg_data[10:0];
        m3kf_pkg::CFG_HEIGHT: image_height <= cfg_data[15:0];
        m3kf_pkg::CFG_IGNORE: ignore_blank <= cfg_data[0];
        m3kf_pkg::CFG_KTOP:   kernel[0]    <= cfg_data;
        m3kf_pkg::CFG_KMID:   kernel[1]    <= cfg_data;
        m3kf_pkg::CFG_KBOT:   kernel[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  m3kf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst, .pix_in, .image_width, .image_height, .restart,
    .q_full, .job, .job_push
  );

  m3kf_queue u_queue (
    .clk, .rst, .push(job_push), .push_job(job), .pop, .head,
    .full(q_full), .empty(q_empty)
  );

  m3kf_back u_back (
    .clk, .rst, .head, .q_empty, .pop, .ignore_blank, .kernel, .pix_out
  );

endmodule
